// File: rtl/qbve_pkg.sv
`default_nettype none
package qbve_pkg;
  localparam int MaxBatchQuads  = 8192;
  localparam int TextureSlots   = 32;
  localparam int SineTableDepth = 256;
  localparam int SlotW  = 5;
  localparam int IdxW   = 8;
  localparam int SlotCells = TextureSlots - 1;

  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_END   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOOKUP, ST_END, ST_ROT, ST_MUL, ST_VERT
  } state_t;

  // Match cell request travelling along the slot chain.
  typedef struct packed {
    logic        valid;
    logic [15:0] tex;
    logic        hit;
    logic [5:0]  hit_slot;
  } probe_t;

  // Quarter-wave sine polynomial, evaluated at elaboration for table entries.
  function automatic logic [16:0] quarter_sine(input logic [16:0] t);
    logic [63:0] t2, v;
    begin
      t2 = ({47'd0, t} * {47'd0, t}) >> 16;
      v  = (64'd5223 * t2) >> 16;
      v  = 64'd42334 - v;
      v  = (v * t2) >> 16;
      v  = 64'd102944 - v;
      v  = (v * {47'd0, t}) >> 16;
      quarter_sine = (v > 64'd65536) ? 17'd65536 : v[16:0];
    end
  endfunction

  // Signed Q16 sine of table entry i.
  function automatic logic signed [17:0] sine_entry(input logic [IdxW-1:0] i);
    logic [17:0] q;
    logic [16:0] t, m;
    begin
      q = {i, 10'd0};
      t = {1'b0, q[15:0]};
      m = q[16] ? quarter_sine(17'd65536 - t) : quarter_sine(t);
      sine_entry = q[17] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    end
  endfunction
endpackage
`default_nettype wire

// File: rtl/qbve_slot_cell.sv
`default_nettype none
module qbve_slot_cell
  import qbve_pkg::*;
(
  input  wire logic       clk,
  input  wire logic [5:0] my_slot,
  input  wire logic       wr,
  input  wire logic [15:0] wr_tex,
  input  wire logic [5:0] used,
  input  wire probe_t     pin,
  output probe_t          pout
);
  logic [15:0] tex;

  // Entry storage; undefined until written.
  always_ff @(posedge clk) begin
    if (wr) tex <= wr_tex;
  end

  // Compare and hand the probe to the next cell.
  always_ff @(posedge clk) begin
    if (pin.valid && !pin.hit && my_slot < used && tex == pin.tex) begin
      pout <= '{valid: pin.valid, tex: pin.tex, hit: 1'b1, hit_slot: my_slot};
    end else begin
      pout <= pin;
    end
  end
endmodule
`default_nettype wire

// File: rtl/quad_batch_vertex_expander.sv
// Channel | Word   | Fields (low bit first)
// s_axis  | in     | tdata: command, cx, cy, cz, w, h, angle, rgba, tex, tiling
// m_axis  | out    | tdata: x, y, z, rgba, corner, slot, tiling, quads, draws, quads_total
//         |        | tuser: kind; tlast: last
// A draw passes the texture match chain of 31 cells, then the rotation
// multiplies, four vertex words, a state that drains the last word and the idle
// state before the next word is accepted. An end drains its word, then idles.
// A batch end ahead of a draw does not delay the draw unless it is still stalled.
// Synchronous reset clears counters and sets the slot fill count to one.
// A stalled output holds the word; the block waits for tready.
`default_nettype none
module quad_batch_vertex_expander
  import qbve_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [247:0] s_axis_tdata,  // command,cx,cy,cz,w,h,angle,rgba,tex,tiling
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [231:0] m_axis_tdata,  // vx,vy,vz,rgba,corner,slot,tiling,bq,draws,quads
  output logic              m_axis_tuser,  // kind
  output logic              m_axis_tlast   // last
);
  state_t state, state_next;
  logic signed [31:0] cx, cy, w, h;
  logic [31:0] cz, rgba;
  logic [15:0] angle, tex, tiling;
  logic [5:0] used, cell_used;
  logic [13:0] quads;
  logic [31:0] draws, qtot;
  logic [5:0] cnt;
  logic [4:0] slot;
  logic [1:0] corner;
  logic signed [17:0] sn, cs;
  logic signed [49:0] wc, ws, hc, hs;
  logic signed [31:0] ox, oy;
  logic full, decide, hit_now, out_free;
  logic signed [17:0] sine_rom [SineTableDepth];

  probe_t chain [SlotCells+1];
  logic [SlotCells-1:0] wr;

  assign s_axis_tready = (state == ST_IDLE);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign chain[0].valid = (state == ST_IDLE) && s_axis_tvalid &&
                          s_axis_tdata[1:0] == CMD_DRAW;
  assign chain[0].tex = s_axis_tdata[225:210];
  assign chain[0].hit = 1'b0;
  assign chain[0].hit_slot = '0;

  assign full = ({2'b0, quads} >= 16'(MaxBatchQuads)) || (used >= 6'(TextureSlots));

  // A batch end taken with the draw empties the table before the first cell compares.
  assign cell_used = (state == ST_IDLE && full) ? 6'd1 : used;

  // The probe leaves the last cell while the count reads one less than the cells.
  assign decide  = (state == ST_LOOKUP) && cnt == 6'(SlotCells - 1);
  assign hit_now = chain[SlotCells].valid && chain[SlotCells].hit;

  // Constant sine table, one entry per angle step.
  for (genvar g = 0; g < SineTableDepth; g++) begin : g_sine
    assign sine_rom[g] = sine_entry(IdxW'(g));
  end

  // Row of match cells, one per non-plain slot.
  for (genvar g = 0; g < SlotCells; g++) begin : g_cell
    assign wr[g] = decide && tex != 16'd0 && !hit_now && used == 6'(g + 1);
    qbve_slot_cell u_cell (
      .clk(clk), .my_slot(6'(g + 1)), .wr(wr[g]), .wr_tex(tex),
      .used(cell_used), .pin(chain[g]), .pout(chain[g+1])
    );
  end

  logic signed [50:0] px, py;
  logic signed [50:0] sx_w, sy_h;
  logic signed [34:0] rx, ry, vx, vy;
  always_comb begin
    sx_w = (corner == 2'd1 || corner == 2'd2) ? 51'(wc) : -51'(wc);
    sy_h = (corner == 2'd2 || corner == 2'd3) ? 51'(hs) : -51'(hs);
    px = sx_w - sy_h;
    py = ((corner == 2'd1 || corner == 2'd2) ? 51'(ws) : -51'(ws)) +
         ((corner == 2'd2 || corner == 2'd3) ? 51'(hc) : -51'(hc));
    rx = 35'((px + 51'sd65536) >>> 17);
    ry = 35'((py + 51'sd65536) >>> 17);
    vx = 35'(cx) + rx;
    vy = 35'(cy) + ry;
    ox = (vx > 35'sd2147483647) ? 32'sh7fffffff :
         (vx < -35'sd2147483648) ? 32'sh80000000 : vx[31:0];
    oy = (vy > 35'sd2147483647) ? 32'sh7fffffff :
         (vy < -35'sd2147483648) ? 32'sh80000000 : vy[31:0];
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_axis_tvalid) begin
        case (s_axis_tdata[1:0])
          CMD_DRAW: state_next = ST_LOOKUP;
          CMD_END:  state_next = ST_END;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_LOOKUP: if (decide) state_next = ST_ROT;
      ST_ROT:    state_next = ST_VERT;
      ST_VERT:   if (out_free && corner == 2'd3) state_next = ST_END;
      ST_END:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Datapath and output word.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 6'd1; quads <= '0; draws <= '0; qtot <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != ST_VERT) m_axis_tvalid <= 1'b0;
      case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          cx <= s_axis_tdata[33:2]; cy <= s_axis_tdata[65:34];
          cz <= s_axis_tdata[97:66]; w <= s_axis_tdata[129:98];
          h <= s_axis_tdata[161:130]; angle <= s_axis_tdata[177:162];
          rgba <= s_axis_tdata[209:178]; tex <= s_axis_tdata[225:210];
          tiling <= s_axis_tdata[241:226];
          cnt <= '0;
          case (s_axis_tdata[1:0])
            CMD_DRAW: begin
              if (full) begin
                draws <= draws + 32'd1;
                m_axis_tvalid <= 1'b1; m_axis_tuser <= 1'b1; m_axis_tlast <= 1'b0;
                m_axis_tdata <= {3'd0, qtot, draws + 32'd1, quads, 151'd0};
                quads <= '0; used <= 6'd1;
              end
            end
            CMD_END: begin
              draws <= draws + 32'd1;
              m_axis_tvalid <= 1'b1; m_axis_tuser <= 1'b1; m_axis_tlast <= 1'b1;
              m_axis_tdata <= {3'd0, qtot, draws + 32'd1, quads, 151'd0};
              quads <= '0; used <= 6'd1;
            end
            CMD_CLEAR: begin draws <= '0; qtot <= '0; end
            default: ;
          endcase
        end
        ST_LOOKUP: begin
          cnt <= cnt + 6'd1;
          if (decide) begin
            if (tex == 16'd0) slot <= '0;
            else if (hit_now) slot <= chain[SlotCells].hit_slot[4:0];
            else if (used < 6'(TextureSlots)) begin
              slot <= used[4:0]; used <= used + 6'd1;
            end else slot <= '0;
            quads <= quads + 14'd1; qtot <= qtot + 32'd1;
            sn <= sine_rom[angle[15:8]];
            cs <= sine_rom[angle[15:8] + 8'd64];
          end
        end
        ST_ROT: begin
          wc <= 50'(w) * 50'(cs); ws <= 50'(w) * 50'(sn);
          hc <= 50'(h) * 50'(cs); hs <= 50'(h) * 50'(sn);
          corner <= 2'd0;
        end
        ST_VERT: if (out_free) begin
          m_axis_tvalid <= 1'b1; m_axis_tuser <= 1'b0;
          m_axis_tlast <= (corner == 2'd3);
          m_axis_tdata <= {3'd0, qtot, draws, quads, tiling, slot, corner, rgba, cz, oy, ox};
          corner <= corner + 2'd1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/qbve_checker.sv
`default_nettype none
module qbve_sva (
  input wire logic clk, rst, s_axis_tvalid, s_axis_tready,
  input wire logic m_axis_tvalid, m_axis_tready, m_axis_tuser, m_axis_tlast,
  input wire logic [231:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word dropped");
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[150:0] == '0)
    else $error("batch end has vertex data");
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken mid item");
endmodule
bind quad_batch_vertex_expander qbve_sva u_chk (.*);
`default_nettype wire
